// ----- rtl/core/jbbc_pkg.sv -----
// Shared types and constants for the JSON bracket balance checker.
package jbbc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned STATUS_W = 2;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam byte_t CH_TERM      = 8'h00;
    localparam byte_t CH_OPEN_BRC  = 8'h7B;  // {
    localparam byte_t CH_CLOSE_BRC = 8'h7D;  // }
    localparam byte_t CH_OPEN_BRK  = 8'h5B;  // [
    localparam byte_t CH_CLOSE_BRK = 8'h5D;  // ]
    localparam byte_t CH_QUOTE     = 8'h22;  // "
    localparam byte_t CH_BSLASH    = 8'h5C;  // backslash

    localparam status_t ST_VALID    = 2'd0;
    localparam status_t ST_TOO_LONG = 2'd1;
    localparam status_t ST_INVALID  = 2'd2;

    localparam len_t MAX_LEN_RESET = 16'd1024;

    // One byte handed from the input stage to the scanner.
    typedef struct packed {
        logic  step;
        byte_t data;
    } scan_req_t;

endpackage

// ----- rtl/core/json_bracket_balance_check.sv -----
// Top level of the JSON bracket balance checker: input beat register, scanner, status register.
//
// Usage: text bytes arrive one per beat on the s_axis channel; a zero byte
// ends the text. Braces and brackets are counted outside string literals,
// a double quote toggles the in-string flag unless the byte just before it
// was a backslash. Each terminator yields exactly one status beat on m_axis
// (0 valid, 1 too long, 2 invalid); other bytes yield nothing.
// max_length is written through cfg_wr_en / cfg_wr_data, by the user only
// while idle (the block itself does not enforce this); it resets to 1024.
// A terminator passes through the input register, then the status register,
// before its status beat shows on m_axis.
// Throughput: one byte per cycle while no terminator waits on a busy m_axis;
// the scanner state is a single register stage.
// Stall: while a status beat waits on m_axis, ordinary bytes keep flowing
// through the scanner; only a further terminator held in the input register
// waits, and s_axis_tready then drops until the status beat is taken.
// Reset (aresetn low, synchronous): both registers empty, all per-text
// state cleared, max_length back to 1024.
module json_bracket_balance_check #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] status, [7:2] zero
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data    // max_length
);
    import jbbc_pkg::*;

    logic      in_valid_reg;
    byte_t     in_byte_reg;
    logic      out_valid_reg, out_valid_next;
    status_t   out_status_reg;
    len_t      max_length_reg;
    status_t   scan_status;
    scan_req_t scan_req;
    logic      in_is_term;
    logic      advance;
    logic      out_free;

    assign in_is_term = (in_byte_reg == CH_TERM);
    assign out_free   = !out_valid_reg || m_axis_tready;
    // Advance the held byte unless it is a terminator with nowhere to go.
    assign advance       = in_valid_reg && (!in_is_term || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    assign scan_req.step = advance;
    assign scan_req.data = in_byte_reg;

    jbbc_scan #(
        .COUNT_BITS(COUNT_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (scan_req),
        .max_length (max_length_reg),
        .status     (scan_status)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance && in_is_term) begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_length_reg <= MAX_LEN_RESET;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                max_length_reg <= cfg_wr_data;
            end
        end
    end

    // Payload: hold the byte until it advances, latch status on a terminator.
    always_ff @(posedge aclk) begin
        if (s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && in_is_term) begin
            out_status_reg <= scan_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8-STATUS_W){1'b0}}, out_status_reg};

    // A status code of three is never produced.
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_status_reg != 2'd3))
        else $error("status code three on output");

    // An empty input stage always takes a beat.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    // A blocked terminator stays put in the input register.
    a_term_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_is_term && out_valid_reg && !m_axis_tready)
        |=> (in_valid_reg && in_is_term))
        else $error("blocked terminator lost");

    // Status beat appears only after a terminator advanced or while held.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(advance && in_is_term))
        else $error("status beat without terminator");

endmodule

// ----- rtl/core/jbbc_scan.sv -----
// Per-text scanner: depth counters, string flags, length and final status.
module jbbc_scan #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  jbbc_pkg::scan_req_t req,
    input  jbbc_pkg::len_t      max_length,
    output jbbc_pkg::status_t   status
);
    import jbbc_pkg::*;

    localparam int unsigned CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    logic [COUNT_BITS-1:0] brace_depth_reg, brace_depth_next;
    logic [COUNT_BITS-1:0] bracket_depth_reg, bracket_depth_next;
    logic [COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic inside_string_reg, inside_string_next;
    logic after_backslash_reg, after_backslash_next;
    logic structure_broken_reg, structure_broken_next;
    logic bad_opening_reg, bad_opening_next;
    logic is_term;
    logic in_str;
    logic [CMP_W-1:0] count_ext, max_ext;

    assign is_term   = (req.data == CH_TERM);
    assign count_ext = CMP_W'(byte_count_reg);
    assign max_ext   = CMP_W'(max_length);

    // Status of the text so far, taken when the terminator steps through.
    always_comb begin
        if (byte_count_reg == '0) begin
            status = ST_INVALID;
        end else if (count_ext > max_ext) begin
            status = ST_TOO_LONG;
        end else if (bad_opening_reg || structure_broken_reg) begin
            status = ST_INVALID;
        end else if (brace_depth_reg != '0 || bracket_depth_reg != '0) begin
            status = ST_INVALID;
        end else begin
            status = ST_VALID;
        end
    end

    always_comb begin
        brace_depth_next      = brace_depth_reg;
        bracket_depth_next    = bracket_depth_reg;
        byte_count_next       = byte_count_reg;
        inside_string_next    = inside_string_reg;
        after_backslash_next  = after_backslash_reg;
        structure_broken_next = structure_broken_reg;
        bad_opening_next      = bad_opening_reg;
        in_str                = inside_string_reg;

        if (req.step && is_term) begin
            brace_depth_next      = '0;
            bracket_depth_next    = '0;
            byte_count_next       = '0;
            inside_string_next    = 1'b0;
            after_backslash_next  = 1'b0;
            structure_broken_next = 1'b0;
            bad_opening_next      = 1'b0;
        end else if (req.step) begin
            if (byte_count_reg == '0 && req.data != CH_OPEN_BRC
                    && req.data != CH_OPEN_BRK) begin
                bad_opening_next = 1'b1;
            end
            if (req.data == CH_QUOTE && !after_backslash_reg) begin
                in_str = !inside_string_reg;
            end
            inside_string_next = in_str;
            if (!in_str) begin
                case (req.data)
                    CH_OPEN_BRC: begin
                        if (brace_depth_reg != CNT_MAX) begin
                            brace_depth_next = brace_depth_reg + CNT_ONE;
                        end
                    end
                    CH_CLOSE_BRC: begin
                        if (brace_depth_reg == '0) begin
                            structure_broken_next = 1'b1;
                        end else begin
                            brace_depth_next = brace_depth_reg - CNT_ONE;
                        end
                    end
                    CH_OPEN_BRK: begin
                        if (bracket_depth_reg != CNT_MAX) begin
                            bracket_depth_next = bracket_depth_reg + CNT_ONE;
                        end
                    end
                    CH_CLOSE_BRK: begin
                        if (bracket_depth_reg == '0) begin
                            structure_broken_next = 1'b1;
                        end else begin
                            bracket_depth_next = bracket_depth_reg - CNT_ONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            after_backslash_next = (req.data == CH_BSLASH);
            if (byte_count_reg != CNT_MAX) begin
                byte_count_next = byte_count_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brace_depth_reg      <= '0;
            bracket_depth_reg    <= '0;
            byte_count_reg       <= '0;
            inside_string_reg    <= 1'b0;
            after_backslash_reg  <= 1'b0;
            structure_broken_reg <= 1'b0;
            bad_opening_reg      <= 1'b0;
        end else begin
            brace_depth_reg      <= brace_depth_next;
            bracket_depth_reg    <= bracket_depth_next;
            byte_count_reg       <= byte_count_next;
            inside_string_reg    <= inside_string_next;
            after_backslash_reg  <= after_backslash_next;
            structure_broken_reg <= structure_broken_next;
            bad_opening_reg      <= bad_opening_next;
        end
    end

endmodule
